### design/assert_macros.svh
// Assertion macros shared by the heap queue RTL.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define CHECK_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// An implication from a condition to a consequent in the next cycle.
`define CHECK_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

// An implication whose consequent holds in the same cycle.
`define CHECK_SAME(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

`endif

### design/bhpq_pkg.sv
// Types, codes and the key compare for the binary heap priority queue.
// No dependencies; used by the top level.
`default_nettype none

package bhpq_pkg;

	localparam int KEY_W    = 32;
	localparam int STATUS_W = 2;
	localparam int POS_W    = 6;
	localparam int OCC_W    = 7;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_EMPTY = 2'd2
	} status_t;

	typedef enum logic {
		MODE_INSERT  = 1'b0,
		MODE_EXTRACT = 1'b1
	} mode_t;

	// Register index as seen on paddr[2].
	localparam logic REG_ORDER_SELECT = 1'b0;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UP_RD,
		ST_UP_CMP,
		ST_DN_ROOT,
		ST_DN_LAST,
		ST_DN_KEY,
		ST_DN_LEFT,
		ST_DN_RIGHT,
		ST_DN_CMP,
		ST_FINISH
	} state_t;

	// True when key a must sit above key b; min_first selects the min-heap order.
	function automatic logic beats(input logic signed [KEY_W-1:0] a,
			input logic signed [KEY_W-1:0] b, input logic min_first);
		return min_first ? (a < b) : (a > b);
	endfunction

endpackage

`default_nettype wire

### design/bhpq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module bhpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

### design/binary_heap_priority_queue_top.sv
// Binary heap priority queue: insert sifts up through ST_UP_RD and ST_UP_CMP for each level
// climbed, extract sifts down through ST_DN_LEFT, ST_DN_RIGHT and ST_DN_CMP for each level
// descended, all through one single-port-read RAM. A full insert or an empty extract goes
// straight to ST_FINISH. One item is in work at a time: in_stall holds until the result
// is registered, and ST_FINISH waits while the output is stalled.
// Reset clears the state, the count, order_select and out_valid only.
`default_nettype none

`include "assert_macros.svh"

module binary_heap_priority_queue_top
	import bhpq_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [2:0]          paddr,
	input  wire logic [31:0]         pwdata,
	output logic      [31:0]         prdata,
	output logic                     pready,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic                mode,
	input  wire logic signed [KEY_W-1:0] key,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [STATUS_W-1:0]      status,
	output logic signed [KEY_W-1:0]  value,
	output logic [POS_W-1:0]         position,
	output logic [OCC_W-1:0]         occupancy
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int LW = AW + 2;

	state_t state_q, state_d;

	logic [CW-1:0]          count_q;
	logic                   order_q;
	logic                   op_q;
	status_t                status_q;
	logic signed [KEY_W-1:0] key_q;
	logic signed [KEY_W-1:0] value_q;
	logic signed [KEY_W-1:0] child_q;
	logic [AW-1:0]          pos_q;
	logic                   left_win_q;
	logic                   right_ok_q;

	logic                   out_valid_q;
	status_t                out_status_q;
	logic signed [KEY_W-1:0] out_value_q;
	logic [POS_W-1:0]       out_pos_q;
	logic [OCC_W-1:0]       out_occ_q;

	logic                   ram_we, ram_re;
	logic [AW-1:0]          ram_waddr, ram_raddr;
	logic [KEY_W-1:0]       ram_wdata, ram_rdata;
	logic signed [KEY_W-1:0] rd_key;

	logic                   in_accept, cfg_write, full, out_free, right_win;
	logic [AW-1:0]          pos_m1, parent;
	logic [LW-1:0]          left_w, right_w, cnt_w;
	logic [AW+POS_W-1:0]    pos_ext;
	logic [CW+OCC_W-1:0]    occ_ext;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign full      = (count_q == CW'(CAPACITY));
	assign out_free  = !out_valid_q || !out_stall;
	assign rd_key    = ram_rdata;

	assign pos_m1  = pos_q - 1'b1;
	assign parent  = pos_m1 >> 1;
	assign left_w  = {1'b0, pos_q, 1'b1};
	assign right_w = left_w + 1'b1;
	assign cnt_w   = {{(LW-CW){1'b0}}, count_q};

	assign right_win = right_ok_q && beats(rd_key, left_win_q ? child_q : key_q, order_q);

	// Configuration port.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign prdata    = (paddr[2] == REG_ORDER_SELECT) ? {31'd0, order_q} : 32'd0;

	bhpq_ram #(
		.WIDTH(KEY_W),
		.DEPTH(CAPACITY)
	) u_store (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(ram_waddr),
		.wr_data(ram_wdata),
		.rd_en  (ram_re),
		.rd_addr(ram_raddr),
		.rd_data(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// The moving key stays in key_q; the RAM slot it passes through is a hole that
	// takes the displaced neighbor, and the key is written once where it stops.
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = key_q;
		ram_re    = 1'b0;
		ram_raddr = parent;
		unique case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					if (mode == MODE_EXTRACT) begin
						state_d = (count_q == '0) ? ST_FINISH : ST_DN_ROOT;
					end else begin
						state_d = full ? ST_FINISH : ST_UP_RD;
					end
				end
			end
			ST_UP_RD: begin
				if (pos_q == '0) begin
					ram_we  = 1'b1;
					state_d = ST_FINISH;
				end else begin
					ram_re  = 1'b1;
					state_d = ST_UP_CMP;
				end
			end
			ST_UP_CMP: begin
				ram_we = 1'b1;
				if (beats(key_q, rd_key, order_q)) begin
					ram_wdata = ram_rdata;
					state_d   = ST_UP_RD;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_DN_ROOT: begin
				ram_re    = 1'b1;
				ram_raddr = '0;
				state_d   = ST_DN_LAST;
			end
			ST_DN_LAST: begin
				ram_re    = 1'b1;
				ram_raddr = count_q[AW-1:0];
				state_d   = ST_DN_KEY;
			end
			ST_DN_KEY: begin
				state_d = (count_q == '0) ? ST_FINISH : ST_DN_LEFT;
			end
			ST_DN_LEFT: begin
				if (left_w >= cnt_w) begin
					ram_we  = 1'b1;
					state_d = ST_FINISH;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = left_w[AW-1:0];
					state_d   = ST_DN_RIGHT;
				end
			end
			ST_DN_RIGHT: begin
				if (right_w < cnt_w) begin
					ram_re    = 1'b1;
					ram_raddr = right_w[AW-1:0];
				end
				state_d = ST_DN_CMP;
			end
			ST_DN_CMP: begin
				ram_we = 1'b1;
				if (right_win) begin
					ram_wdata = ram_rdata;
					state_d   = ST_DN_LEFT;
				end else if (left_win_q) begin
					ram_wdata = child_q;
					state_d   = ST_DN_LEFT;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			order_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write && paddr[2] == REG_ORDER_SELECT) begin
				order_q <= pwdata[0];
			end
			if (in_accept) begin
				if (mode == MODE_EXTRACT) begin
					if (count_q != '0) begin
						count_q <= count_q - 1'b1;
					end
				end else if (!full) begin
					count_q <= count_q + 1'b1;
				end
			end
			if (state_q == ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					op_q  <= mode;
					key_q <= key;
					if (mode == MODE_EXTRACT) begin
						status_q <= (count_q == '0) ? STATUS_EMPTY : STATUS_OK;
						pos_q    <= '0;
					end else begin
						status_q <= full ? STATUS_FULL : STATUS_OK;
						pos_q    <= count_q[AW-1:0];
					end
				end
			end
			ST_UP_CMP: begin
				if (beats(key_q, rd_key, order_q)) begin
					pos_q <= parent;
				end
			end
			ST_DN_LAST: begin
				value_q <= rd_key;
			end
			ST_DN_KEY: begin
				key_q <= rd_key;
			end
			ST_DN_RIGHT: begin
				child_q    <= rd_key;
				left_win_q <= beats(rd_key, key_q, order_q);
				right_ok_q <= (right_w < cnt_w);
			end
			ST_DN_CMP: begin
				if (right_win) begin
					pos_q <= right_w[AW-1:0];
				end else if (left_win_q) begin
					pos_q <= left_w[AW-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign pos_ext = {{POS_W{1'b0}}, pos_q};
	assign occ_ext = {{OCC_W{1'b0}}, count_q};

	// Output register.
	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_free) begin
			out_status_q <= status_q;
			out_value_q  <= (op_q == MODE_EXTRACT && status_q == STATUS_OK) ? value_q : '0;
			out_pos_q    <= (op_q == MODE_INSERT && status_q == STATUS_OK) ?
				pos_ext[POS_W-1:0] : '0;
			out_occ_q    <= occ_ext[OCC_W-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign value     = out_value_q;
	assign position  = out_pos_q;
	assign occupancy = out_occ_q;

	`CHECK_ALWAYS(a_count_bound, count_q <= CW'(CAPACITY), "entry count above capacity")
	`CHECK_NEXT(a_count_only_on_accept, !in_accept, $stable(count_q), "count moved without an item")
	`CHECK_NEXT(a_accept_leaves_idle, in_accept, state_q != ST_IDLE, "accepted item not worked on")
	`CHECK_SAME(a_result_from_finish, $rose(out_valid), $past(state_q == ST_FINISH),
		"result shown without a finished item")

endmodule

`default_nettype wire
